>>> hdl/bbs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbs_pkg: ball bounce step shared definitions
// Fixed-point format, box configuration layout, ball state and edge helpers.
// ----------------------------------------------------------------------------
package bbs_pkg;

	localparam int FRAC_BITS = 16;
	localparam int POS_W     = 32;
	localparam int PIX_W     = 12;
	localparam int CMP_W     = POS_W + 2;
	localparam int CFG_IDX_W = 3;
	localparam int CNT_W     = 2;

	typedef logic signed [CMP_W-1:0] wide_t;
	typedef logic signed [POS_W-1:0] pos_t;
	typedef logic [PIX_W-1:0]        pix_t;
	typedef logic [CNT_W-1:0]        cnt_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_OUTER_LEFT   = 3'd0,
		REG_OUTER_RIGHT  = 3'd1,
		REG_OUTER_TOP    = 3'd2,
		REG_OUTER_BOTTOM = 3'd3,
		REG_INNER_LEFT   = 3'd4,
		REG_INNER_RIGHT  = 3'd5,
		REG_INNER_TOP    = 3'd6,
		REG_INNER_BOTTOM = 3'd7
	} cfg_reg_t;

	localparam pix_t RST_OUTER_LEFT   = 12'd0;
	localparam pix_t RST_OUTER_RIGHT  = 12'd639;
	localparam pix_t RST_OUTER_TOP    = 12'd0;
	localparam pix_t RST_OUTER_BOTTOM = 12'd479;
	localparam pix_t RST_INNER_LEFT   = 12'd280;
	localparam pix_t RST_INNER_RIGHT  = 12'd360;
	localparam pix_t RST_INNER_TOP    = 12'd200;
	localparam pix_t RST_INNER_BOTTOM = 12'd280;

	typedef struct packed {
		pix_t outer_left;
		pix_t outer_right;
		pix_t outer_top;
		pix_t outer_bottom;
		pix_t inner_left;
		pix_t inner_right;
		pix_t inner_top;
		pix_t inner_bottom;
	} box_cfg_t;

	typedef struct packed {
		pos_t x;
		pos_t y;
		pos_t vx;
		pos_t vy;
	} ball_t;

	// One whole pixel in the wide compare format
	localparam wide_t ONE_W = {{(CMP_W-1){1'b0}}, 1'b1} << FRAC_BITS;

	function automatic wide_t edge_pos(input pix_t px);
		wide_t w;
		w = {{(CMP_W-PIX_W){1'b0}}, px};
		return w << FRAC_BITS;
	endfunction

	function automatic wide_t widen(input pos_t v);
		return {{(CMP_W-POS_W){v[POS_W-1]}}, v};
	endfunction

endpackage

>>> hdl/bbs_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbs_cfg_regs: box edge registers
// Holds the outer arena and inner obstacle edges written through the port.
// ----------------------------------------------------------------------------
module bbs_cfg_regs import bbs_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  pix_t                 cfg_data,
	output box_cfg_t             box
);

	box_cfg_t box_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_q.outer_left   <= RST_OUTER_LEFT;
			box_q.outer_right  <= RST_OUTER_RIGHT;
			box_q.outer_top    <= RST_OUTER_TOP;
			box_q.outer_bottom <= RST_OUTER_BOTTOM;
			box_q.inner_left   <= RST_INNER_LEFT;
			box_q.inner_right  <= RST_INNER_RIGHT;
			box_q.inner_top    <= RST_INNER_TOP;
			box_q.inner_bottom <= RST_INNER_BOTTOM;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_OUTER_LEFT:   box_q.outer_left   <= cfg_data;
				REG_OUTER_RIGHT:  box_q.outer_right  <= cfg_data;
				REG_OUTER_TOP:    box_q.outer_top    <= cfg_data;
				REG_OUTER_BOTTOM: box_q.outer_bottom <= cfg_data;
				REG_INNER_LEFT:   box_q.inner_left   <= cfg_data;
				REG_INNER_RIGHT:  box_q.inner_right  <= cfg_data;
				REG_INNER_TOP:    box_q.inner_top    <= cfg_data;
				REG_INNER_BOTTOM: box_q.inner_bottom <= cfg_data;
				default:          box_q              <= box_q;
			endcase
		end
	end

	assign box = box_q;

endmodule

>>> hdl/bbs_update.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbs_update: one tick of ball motion
// Moves the ball, clamps it against the arena and reflects it off the obstacle.
// ----------------------------------------------------------------------------
module bbs_update import bbs_pkg::*; (
	input  box_cfg_t box,
	input  ball_t    cur,
	output ball_t    nxt,
	output cnt_t     bounce
);

	typedef struct packed {
		pos_t p;
		pos_t v;
		logic hit;
	} axis_t;

	// Clamp low edge first, then high edge on the already clamped value
	function automatic axis_t outer_axis(input pos_t p, input pos_t v,
		input pix_t lo_px, input pix_t hi_px);
		axis_t r;
		wide_t lo;
		wide_t hi;
		wide_t a;
		pos_t  va;
		logic  hl;
		logic  hh;
		lo = edge_pos(lo_px) + ONE_W;
		hi = edge_pos(hi_px) - ONE_W;
		a  = widen(p);
		hl = a < lo;
		if (hl) a = lo;
		va = hl ? -v : v;
		hh = a > hi;
		if (hh) a = hi;
		r.p   = a[POS_W-1:0];
		r.v   = hh ? -va : va;
		r.hit = hl | hh;
		return r;
	endfunction

	// Place the axis just outside the edge it came through
	function automatic axis_t inner_axis(input pos_t c, input pos_t n, input pos_t v,
		input wide_t lo, input wide_t hi);
		axis_t r;
		wide_t wc;
		wide_t t;
		wc = widen(c);
		r.p   = n;
		r.v   = v;
		r.hit = 1'b0;
		if (wc < lo) begin
			t     = lo - ONE_W;
			r.p   = t[POS_W-1:0];
			r.v   = -v;
			r.hit = 1'b1;
		end else if (wc > hi) begin
			t     = hi + ONE_W;
			r.p   = t[POS_W-1:0];
			r.v   = -v;
			r.hit = 1'b1;
		end
		return r;
	endfunction

	axis_t ox;
	axis_t oy;
	axis_t ix;
	axis_t iy;
	pos_t  nx;
	pos_t  ny;
	wide_t ilx;
	wide_t ihx;
	wide_t ily;
	wide_t ihy;
	logic  in_obstacle;
	logic  inner_hit;

	always_comb begin
		ox = outer_axis(cur.x + cur.vx, cur.vx, box.outer_left, box.outer_right);
		oy = outer_axis(cur.y + cur.vy, cur.vy, box.outer_top, box.outer_bottom);

		ilx = edge_pos(box.inner_left);
		ihx = edge_pos(box.inner_right);
		ily = edge_pos(box.inner_top);
		ihy = edge_pos(box.inner_bottom);

		nx = ox.p + ox.v;
		ny = oy.p + oy.v;
		in_obstacle = (widen(nx) >= ilx) && (widen(nx) <= ihx) &&
			(widen(ny) >= ily) && (widen(ny) <= ihy);

		ix = inner_axis(ox.p, nx, ox.v, ilx, ihx);
		iy = inner_axis(oy.p, ny, oy.v, ily, ihy);

		// Obstacle: bounce off the edge entered; outside: hold the clamped position
		if (in_obstacle) begin
			nxt.x  = ix.p;
			nxt.y  = iy.p;
			nxt.vx = ix.v;
			nxt.vy = iy.v;
			inner_hit = ix.hit | iy.hit;
		end else begin
			nxt.x  = ox.p;
			nxt.y  = oy.p;
			nxt.vx = ox.v;
			nxt.vy = oy.v;
			inner_hit = 1'b0;
		end

		bounce = {1'b0, ox.hit | oy.hit} + {1'b0, inner_hit};
	end

endmodule

>>> hdl/ball_bounce_step_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ball_bounce_step_unit: ball bounce step
// Path: input register, then one update pass into the result and ball state
//   registers. Throughput: one item per cycle while the output is not stalled;
//   the ball state feeds back within the pass.
// Reset: ball state clears to zero, box edges return to their defaults,
//   both pipeline slots empty.
// ----------------------------------------------------------------------------
module ball_bounce_step_unit import bbs_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [PIX_W-1:0]     cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 req_type,
	input  logic signed [POS_W-1:0] load_pos_x,
	input  logic signed [POS_W-1:0] load_pos_y,
	input  logic signed [POS_W-1:0] load_vel_x,
	input  logic signed [POS_W-1:0] load_vel_y,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic signed [POS_W-1:0] pos_x,
	output logic signed [POS_W-1:0] pos_y,
	output logic signed [POS_W-1:0] vel_x,
	output logic signed [POS_W-1:0] vel_y,
	output logic [CNT_W-1:0]     bounce_count
);

	box_cfg_t box;
	ball_t    ball_q;
	ball_t    step_nxt;
	ball_t    upd;
	cnt_t     step_cnt;
	cnt_t     upd_cnt;

	logic  valid_s1;
	logic  req_type_s1;
	ball_t load_s1;
	logic  advance;
	logic  accept_in;

	logic  out_valid_q;
	ball_t res_q;
	cnt_t  cnt_q;

	bbs_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.box       (box)
	);

	bbs_update u_update (
		.box    (box),
		.cur    (ball_q),
		.nxt    (step_nxt),
		.bounce (step_cnt)
	);

	// Result slot is free or being drained this cycle
	assign advance   = !out_valid_q || !out_stall;
	assign in_stall  = valid_s1 && !advance;
	assign accept_in = in_valid && !in_stall;

	always_comb begin
		if (req_type_s1) begin
			upd     = load_s1;
			upd_cnt = '0;
		end else begin
			upd     = step_nxt;
			upd_cnt = step_cnt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept_in) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept_in) begin
			req_type_s1 <= req_type;
			load_s1.x   <= load_pos_x;
			load_s1.y   <= load_pos_y;
			load_s1.vx  <= load_vel_x;
			load_s1.vy  <= load_vel_y;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ball_q      <= '0;
			out_valid_q <= 1'b0;
		end else if (valid_s1 && advance) begin
			ball_q      <= upd;
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && advance) begin
			res_q <= upd;
			cnt_q <= upd_cnt;
		end
	end

	assign out_valid    = out_valid_q;
	assign pos_x        = res_q.x;
	assign pos_y        = res_q.y;
	assign vel_x        = res_q.vx;
	assign vel_y        = res_q.vy;
	assign bounce_count = cnt_q;

`ifndef SYNTHESIS
	a_issue_fills_out : assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && advance |=> out_valid)
		else $error("issued item did not reach the result register");

	a_blocked_holds : assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(load_s1) && $stable(req_type_s1))
		else $error("blocked item lost or changed");

	a_load_result : assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && advance && req_type_s1 |=> bounce_count == '0 && pos_x == $past(load_s1.x)
			&& vel_y == $past(load_s1.vy))
		else $error("load result does not match loaded state");

	a_state_matches_out : assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && advance |=> ball_q == res_q)
		else $error("ball state and reported result differ");

	a_count_range : assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> bounce_count != 2'd3)
		else $error("bounce count out of range");
`endif

endmodule

>>> dv/ball_bounce_step_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ball_bounce_step_unit_test: self-checking bench for the ball bounce step
// Drives load and tick transactions through several arena/obstacle settings.
// Both channels get random gaps and stalls, and one long output hold-off.
// A scoreboard predicts every result and checks it field by field.
// ----------------------------------------------------------------------------
module ball_bounce_step_unit_test;
	import bbs_pkg::*;

	localparam logic   REQ_TICK    = 1'b0;
	localparam logic   REQ_LOAD    = 1'b1;
	localparam longint ONE_PX      = longint'(1) <<< FRAC_BITS;
	localparam int     CYCLE_LIMIT = 600000;
	localparam int     PHASE_ITEMS = 230;

	typedef struct {
		pos_t x;
		pos_t y;
		pos_t vx;
		pos_t vy;
		cnt_t bounces;
	} ball_result_t;

	typedef pix_t box_vals_t [8];

	class bounce_scoreboard;
		pix_t         edges [8];
		pos_t         bx, by, vx, vy;
		ball_result_t expected_states [$];
		int           errors;

		function new();
			edges[REG_OUTER_LEFT]   = RST_OUTER_LEFT;
			edges[REG_OUTER_RIGHT]  = RST_OUTER_RIGHT;
			edges[REG_OUTER_TOP]    = RST_OUTER_TOP;
			edges[REG_OUTER_BOTTOM] = RST_OUTER_BOTTOM;
			edges[REG_INNER_LEFT]   = RST_INNER_LEFT;
			edges[REG_INNER_RIGHT]  = RST_INNER_RIGHT;
			edges[REG_INNER_TOP]    = RST_INNER_TOP;
			edges[REG_INNER_BOTTOM] = RST_INNER_BOTTOM;
			bx = '0;
			by = '0;
			vx = '0;
			vy = '0;
			errors = 0;
		endfunction

		function void set_edge(cfg_reg_t idx, pix_t val);
			edges[idx] = val;
		endfunction

		function int outstanding();
			return expected_states.size();
		endfunction

		function longint wide(pos_t v);
			return longint'(v);
		endfunction

		function longint edge_of(pix_t p);
			return longint'(p) <<< FRAC_BITS;
		endfunction

		// Clamp each axis one pixel inside the arena, in left/right/top/bottom order
		function int clamp_outer();
			longint lo_x, hi_x, lo_y, hi_y;
			int     hit;
			lo_x = edge_of(edges[REG_OUTER_LEFT]) + ONE_PX;
			hi_x = edge_of(edges[REG_OUTER_RIGHT]) - ONE_PX;
			lo_y = edge_of(edges[REG_OUTER_TOP]) + ONE_PX;
			hi_y = edge_of(edges[REG_OUTER_BOTTOM]) - ONE_PX;
			hit = 0;
			if (wide(bx) < lo_x) begin
				bx = pos_t'(lo_x);
				vx = -vx;
				hit = 1;
			end
			if (wide(bx) > hi_x) begin
				bx = pos_t'(hi_x);
				vx = -vx;
				hit = 1;
			end
			if (wide(by) < lo_y) begin
				by = pos_t'(lo_y);
				vy = -vy;
				hit = 1;
			end
			if (wide(by) > hi_y) begin
				by = pos_t'(hi_y);
				vy = -vy;
				hit = 1;
			end
			return hit;
		endfunction

		// Move only if the next point lands in the obstacle; reflect axes that entered
		function int enter_inner();
			longint lo_x, hi_x, lo_y, hi_y;
			pos_t   nx, ny;
			int     hit;
			lo_x = edge_of(edges[REG_INNER_LEFT]);
			hi_x = edge_of(edges[REG_INNER_RIGHT]);
			lo_y = edge_of(edges[REG_INNER_TOP]);
			hi_y = edge_of(edges[REG_INNER_BOTTOM]);
			nx = bx + vx;
			ny = by + vy;
			hit = 0;
			if (!(wide(nx) >= lo_x && wide(nx) <= hi_x && wide(ny) >= lo_y && wide(ny) <= hi_y))
				return 0;
			if (wide(bx) < lo_x) begin
				vx = -vx;
				nx = pos_t'(lo_x - ONE_PX);
				hit = 1;
			end else if (wide(bx) > hi_x) begin
				vx = -vx;
				nx = pos_t'(hi_x + ONE_PX);
				hit = 1;
			end
			if (wide(by) < lo_y) begin
				vy = -vy;
				ny = pos_t'(lo_y - ONE_PX);
				hit = 1;
			end else if (wide(by) > hi_y) begin
				vy = -vy;
				ny = pos_t'(hi_y + ONE_PX);
				hit = 1;
			end
			bx = nx;
			by = ny;
			return hit;
		endfunction

		function void note_input(logic rt, pos_t a, pos_t b, pos_t c, pos_t d);
			ball_result_t res;
			int           hits;
			hits = 0;
			if (rt == REQ_LOAD) begin
				bx = a;
				by = b;
				vx = c;
				vy = d;
			end else begin
				bx = bx + vx;
				by = by + vy;
				hits = clamp_outer();
				hits += enter_inner();
			end
			res = '{bx, by, vx, vy, cnt_t'(hits)};
			expected_states.push_back(res);
		endfunction

		task report(string msg);
			$display("MISMATCH at %0t ns: %s", $time, msg);
			errors++;
		endtask

		task check_result(pos_t x, pos_t y, pos_t qx, pos_t qy, cnt_t c);
			ball_result_t e;
			if (expected_states.size() == 0) begin
				report("result transaction with nothing expected");
				return;
			end
			e = expected_states.pop_front();
			if (x !== e.x)
				report($sformatf("pos_x got %h want %h", x, e.x));
			if (y !== e.y)
				report($sformatf("pos_y got %h want %h", y, e.y));
			if (qx !== e.vx)
				report($sformatf("vel_x got %h want %h", qx, e.vx));
			if (qy !== e.vy)
				report($sformatf("vel_y got %h want %h", qy, e.vy));
			if (c !== e.bounces)
				report($sformatf("bounce_count got %0d want %0d", c, e.bounces));
		endtask
	endclass

	logic                 clk          = 1'b0;
	logic                 arst_n       = 1'b0;
	logic                 cfg_we       = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index    = REG_OUTER_LEFT;
	logic [PIX_W-1:0]     cfg_data     = '0;
	logic                 in_valid     = 1'b0;
	logic                 in_stall;
	logic                 req_type     = REQ_TICK;
	pos_t                 load_pos_x   = '0;
	pos_t                 load_pos_y   = '0;
	pos_t                 load_vel_x   = '0;
	pos_t                 load_vel_y   = '0;
	logic                 out_valid;
	logic                 out_stall    = 1'b0;
	pos_t                 pos_x;
	pos_t                 pos_y;
	pos_t                 vel_x;
	pos_t                 vel_y;
	cnt_t                 bounce_count;

	bounce_scoreboard sb = new();
	int cycles       = 0;
	int results_seen = 0;
	int tx_calm      = 0;
	int rx_calm      = 0;
	int stall_left   = 0;
	bit hold_done    = 1'b0;

	ball_bounce_step_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.req_type     (req_type),
		.load_pos_x   (load_pos_x),
		.load_pos_y   (load_pos_y),
		.load_vel_x   (load_vel_x),
		.load_vel_y   (load_vel_y),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.vel_x        (vel_x),
		.vel_y        (vel_y),
		.bounce_count (bounce_count)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("ball_bounce_step_unit test failed");
			$finish;
		end
	end

	// Mostly short gaps, a few long ones, and now and then a stretch with none
	function automatic int pick_gap(inout int calm);
		int r;
		if (calm > 0) begin
			calm--;
			return 0;
		end
		r = $urandom_range(99);
		if (r < 3) begin
			calm = $urandom_range(20, 60);
			return 0;
		end
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic pos_t pixels(int p);
		return pos_t'(p <<< FRAC_BITS);
	endfunction

	function automatic pos_t rand_coord(pix_t e0, pix_t e1);
		int a, b, lo, hi, p;
		a = e0;
		b = e1;
		lo = (a < b ? a : b) - 40;
		hi = (a < b ? b : a) + 40;
		p = lo + int'($urandom_range(hi - lo));
		return pos_t'((p <<< FRAC_BITS) + int'($urandom_range(16'hFFFF)));
	endfunction

	function automatic pos_t rand_speed();
		int r, mag;
		r = $urandom_range(99);
		if (r < 5)
			mag = 0;
		else if (r < 85)
			mag = (int'($urandom_range(0, 12)) <<< FRAC_BITS) + int'($urandom_range(16'hFFFF));
		else
			mag = (int'($urandom_range(13, 700)) <<< FRAC_BITS) + int'($urandom_range(16'hFFFF));
		return $urandom_range(1) ? pos_t'(-mag) : pos_t'(mag);
	endfunction

	always @(negedge clk) begin
		// One long hold-off so the pipeline fills and backs up into the input
		if (!hold_done && results_seen >= 200) begin
			hold_done = 1'b1;
			stall_left = 150;
		end
		if (stall_left > 0) begin
			out_stall = 1'b1;
			stall_left--;
		end else begin
			out_stall = 1'b0;
			stall_left = pick_gap(rx_calm);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
			sb.check_result(pos_x, pos_y, vel_x, vel_y, bounce_count);
			results_seen++;
		end
	end

	task automatic send_item(input logic rt, input pos_t a, input pos_t b,
		input pos_t c, input pos_t d);
		int gap;
		gap = pick_gap(tx_calm);
		repeat (gap) begin
			@(negedge clk);
			in_valid = 1'b0;
		end
		@(negedge clk);
		req_type   = rt;
		load_pos_x = a;
		load_pos_y = b;
		load_vel_x = c;
		load_vel_y = d;
		in_valid   = 1'b1;
		do
			@(posedge clk);
		while (in_stall !== 1'b0);
		sb.note_input(rt, a, b, c, d);
	endtask

	task automatic send_load(input pos_t a, input pos_t b, input pos_t c, input pos_t d);
		send_item(REQ_LOAD, a, b, c, d);
	endtask

	// Load fields carry noise on a tick
	task automatic send_tick();
		send_item(REQ_TICK, pos_t'($urandom), pos_t'($urandom), pos_t'($urandom),
			pos_t'($urandom));
	endtask

	// Drop valid, drain all results, then let the pipeline go quiet
	task automatic settle();
		@(negedge clk);
		in_valid = 1'b0;
		while (sb.outstanding() > 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic apply_box(input box_vals_t vals);
		cfg_reg_t r;
		r = r.first();
		do begin
			@(negedge clk);
			cfg_we    = 1'b1;
			cfg_index = r;
			cfg_data  = vals[r];
			sb.set_edge(r, vals[r]);
			r = r.next();
		end while (r != r.first());
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic run_directed();
		send_tick();
		send_load(pixels(100) + 32'sh8000, pixels(100), pixels(3) + 32'sh8000,
			-pixels(2) - 32'sh4000);
		send_tick();
		send_load(pixels(2), pixels(50), -pixels(5), pixels(1));
		send_tick();
		send_load(pixels(636), pixels(476), pixels(6), pixels(7));
		send_tick();
		// approach the obstacle from each side
		send_load(pixels(275), pixels(240), pixels(4), 0);
		send_tick();
		send_load(pixels(365), pixels(240), -pixels(4), 0);
		send_tick();
		send_load(pixels(320), pixels(195), 0, pixels(4));
		send_tick();
		send_load(pixels(320), pixels(285), 0, -pixels(4));
		send_tick();
		// arena bounce followed by an obstacle bounce in the same tick
		send_load(-pixels(10), pixels(240), -pixels(290), 0);
		send_tick();
		// position wraps past the positive limit
		send_load(32'sh7FFF0000, pixels(100), 32'sh00020000, 0);
		send_tick();
		// negating the most negative velocity leaves it unchanged
		send_load(pixels(100), pixels(100), 32'sh80000000, 32'sh80000000);
		send_tick();
		send_load(32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF, 32'shFFFFFFFF);
		send_tick();
		send_load(-1, -1, -1, -1);
		send_tick();
		send_load(0, 0, 0, 0);
	endtask

	task automatic run_random(input int n);
		int r;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(99);
			if (r < 5)
				send_load(rand_coord(sb.edges[REG_OUTER_LEFT], sb.edges[REG_OUTER_RIGHT]),
					rand_coord(sb.edges[REG_OUTER_TOP], sb.edges[REG_OUTER_BOTTOM]),
					rand_speed(), rand_speed());
			else if (r < 10)
				send_load(rand_coord(sb.edges[REG_INNER_LEFT], sb.edges[REG_INNER_RIGHT]),
					rand_coord(sb.edges[REG_INNER_TOP], sb.edges[REG_INNER_BOTTOM]),
					rand_speed(), rand_speed());
			else if (r < 14)
				send_load(pos_t'($urandom), pos_t'($urandom), pos_t'($urandom),
					pos_t'($urandom));
			else
				send_tick();
		end
	endtask

	initial begin
		box_vals_t rand_box;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		run_directed();
		run_random(PHASE_ITEMS);

		settle();
		apply_box('{12'd0, 12'd4095, 12'd0, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd4095});
		run_random(PHASE_ITEMS);

		settle();
		apply_box('{12'd10, 12'd200, 12'd20, 12'd150, 12'd80, 12'd120, 12'd60, 12'd100});
		run_random(PHASE_ITEMS);

		// arena limits cross over: clamps may fire twice per axis
		settle();
		apply_box('{12'd300, 12'd100, 12'd250, 12'd50, 12'd0, 12'd0, 12'd0, 12'd0});
		run_random(PHASE_ITEMS);

		// obstacle limits cross over: nothing lands inside it
		settle();
		apply_box('{12'd0, 12'd639, 12'd0, 12'd479, 12'd400, 12'd200, 12'd300, 12'd100});
		run_random(PHASE_ITEMS);

		settle();
		apply_box('{12'd4095, 12'd0, 12'd4095, 12'd0, 12'd0, 12'd4095, 12'd0, 12'd4095});
		run_random(PHASE_ITEMS);

		settle();
		foreach (rand_box[k])
			rand_box[k] = pix_t'($urandom_range(4095));
		apply_box(rand_box);
		run_random(PHASE_ITEMS);

		settle();
		apply_box('{RST_OUTER_LEFT, RST_OUTER_RIGHT, RST_OUTER_TOP, RST_OUTER_BOTTOM,
			RST_INNER_LEFT, RST_INNER_RIGHT, RST_INNER_TOP, RST_INNER_BOTTOM});
		run_random(PHASE_ITEMS);

		settle();
		repeat (10) @(posedge clk);
		if (sb.errors == 0 && sb.outstanding() == 0)
			$display("ball_bounce_step_unit test passed");
		else
			$display("ball_bounce_step_unit test failed");
		$finish;
	end

endmodule
